>>> rtl/tlbpt_pkg.sv
// tlbpt_pkg: shared types and helpers for the tlb / page table translator
// no dependencies; imported by every module under rtl
package tlbpt_pkg;

  localparam int PageW  = 8;
  localparam int FrameW = 8;
  localparam int CountW = 32;
  localparam int AddrW  = 16;
  localparam int NffW   = 9;

  typedef logic [PageW-1:0]  page_t;
  typedef logic [FrameW-1:0] frame_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [AddrW-1:0]  addr_t;
  typedef logic [NffW-1:0]   nff_t;

  localparam count_t CountMax = '1;
  localparam nff_t   NffMax   = '1;

  typedef struct packed {
    logic   valid;
    page_t  tag;
    frame_t frame;
  } tlbpt_entry_t;

  typedef struct packed {
    logic insert;
    logic full;
  } tlbpt_cell_ctl_t;

  function automatic count_t sat_inc(input count_t v);
    return (v == CountMax) ? v : v + count_t'(1);
  endfunction

endpackage

>>> rtl/tlbpt_cell.sv
// tlbpt_cell: one tlb entry in the fifo row; compares its tag and shifts left
// depends on tlbpt_pkg
module tlbpt_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  tlbpt_pkg::tlbpt_cell_ctl_t ctl,
  input  logic                      left_valid,
  input  tlbpt_pkg::tlbpt_entry_t   right_entry,
  input  tlbpt_pkg::tlbpt_entry_t   new_entry,
  input  tlbpt_pkg::page_t          search_page,
  output tlbpt_pkg::tlbpt_entry_t   entry,
  output logic                      match
);
  import tlbpt_pkg::*;

  logic load;
  logic shift;

  assign shift = ctl.insert && ctl.full;
  assign load  = ctl.insert && !ctl.full && !entry.valid && left_valid;
  assign match = entry.valid && (entry.tag == search_page);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (shift) begin
      entry <= right_entry;
    end else if (load) begin
      entry <= new_entry;
    end
  end

endmodule

>>> rtl/tlbpt_page_table.sv
// tlbpt_page_table: page table memory with per-page mapped bits, registered read
// depends on tlbpt_pkg
module tlbpt_page_table #(
  parameter int PAGE_COUNT = 256,
  localparam int PgW = $clog2(PAGE_COUNT)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [PgW-1:0]       rd_page,
  input  logic                 wr_en,
  input  logic [PgW-1:0]       wr_page,
  input  tlbpt_pkg::frame_t    wr_frame,
  output tlbpt_pkg::frame_t    rd_frame,
  output logic                 rd_mapped
);
  import tlbpt_pkg::*;

  frame_t                mem [PAGE_COUNT];
  logic [PAGE_COUNT-1:0] mapped;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_page] <= wr_frame;
    end
    if (rd_en) begin
      rd_frame <= mem[rd_page];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mapped    <= '0;
      rd_mapped <= 1'b0;
    end else begin
      if (wr_en) begin
        mapped[wr_page] <= 1'b1;
      end
      if (rd_en) begin
        rd_mapped <= mapped[rd_page];
      end
    end
  end

endmodule

>>> rtl/tlb_page_table_translator.sv
// tlb_page_table_translator: tlb (fifo row of cells) plus page table with demand paging
// depends on tlbpt_pkg, tlbpt_cell, tlbpt_page_table
//
//   channel   handshake          payload
//   input     start / busy       logical_address
//   result    done (one cycle)   physical_address, frame_number, page_number,
//                                tlb_hit, page_fault, lookup_total, hit_total, fault_total
//
// each item does the page table memory read, then the tlb compare and, on a page fault, the update
// done rises the cycle after the lookup and a new item may start in that same cycle
// busy is high during the lookup cycle only
// synchronous reset empties the tlb, clears every mapped bit and the counters
// the receiver cannot stall; each result is shown for exactly one cycle
module tlb_page_table_translator #(
  parameter int TLB_ENTRIES = 16,
  parameter int PAGE_COUNT  = 256,
  parameter int PAGE_SIZE   = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  tlbpt_pkg::addr_t    logical_address,
  output logic                done,
  output tlbpt_pkg::addr_t    physical_address,
  output tlbpt_pkg::frame_t   frame_number,
  output tlbpt_pkg::page_t    page_number,
  output logic                tlb_hit,
  output logic                page_fault,
  output tlbpt_pkg::count_t   lookup_total,
  output tlbpt_pkg::count_t   hit_total,
  output tlbpt_pkg::count_t   fault_total
);
  import tlbpt_pkg::*;

  localparam int OffW = $clog2(PAGE_SIZE);
  localparam int PgW  = $clog2(PAGE_COUNT);

  typedef enum logic {ST_IDLE, ST_LOOK} state_t;

  state_t             state;
  logic [PgW-1:0]     page_q;
  logic [OffW-1:0]    offset_q;
  nff_t               next_free_frame;
  count_t             lookup_counter;
  count_t             hit_counter;
  count_t             fault_counter;

  logic               accept;
  logic [PgW-1:0]     in_page;
  frame_t             pt_frame;
  logic               pt_mapped;
  page_t              search_page;
  tlbpt_entry_t       cells [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] match;
  tlbpt_entry_t       new_entry;
  tlbpt_cell_ctl_t    ctl;
  logic               hit;
  logic               fault;
  frame_t             tlb_frame;
  frame_t             frame_sel;
  logic [23:0]        pa_wide;

  assign busy        = (state == ST_LOOK);
  assign accept      = start && !busy;
  assign in_page     = logical_address[OffW +: PgW];
  assign search_page = page_t'(page_q);

  tlbpt_page_table #(
    .PAGE_COUNT(PAGE_COUNT)
  ) u_pt (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_page  (in_page),
    .wr_en    (fault),
    .wr_page  (page_q),
    .wr_frame (next_free_frame[FrameW-1:0]),
    .rd_frame (pt_frame),
    .rd_mapped(pt_mapped)
  );

  assign new_entry.valid = 1'b1;
  assign new_entry.tag   = search_page;
  assign new_entry.frame = next_free_frame[FrameW-1:0];
  assign ctl.insert      = fault;
  assign ctl.full        = cells[TLB_ENTRIES-1].valid;

  for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_cell
    tlbpt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .left_valid ((i == 0) ? 1'b1 : cells[(i == 0) ? 0 : i-1].valid),
      .right_entry((i == TLB_ENTRIES-1) ? new_entry
                                        : cells[(i == TLB_ENTRIES-1) ? i : i+1]),
      .new_entry  (new_entry),
      .search_page(search_page),
      .entry      (cells[i]),
      .match      (match[i])
    );
  end

  always_comb begin
    tlb_frame = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      tlb_frame = tlb_frame | (cells[i].frame & {FrameW{match[i]}});
    end
  end

  assign hit       = (state == ST_LOOK) && (|match);
  assign fault     = (state == ST_LOOK) && !(|match) && !pt_mapped;
  assign frame_sel = (|match) ? tlb_frame
                   : (pt_mapped ? pt_frame : next_free_frame[FrameW-1:0]);
  assign pa_wide   = 24'({frame_sel, offset_q});

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      done            <= 1'b0;
      next_free_frame <= '0;
      lookup_counter  <= '0;
      hit_counter     <= '0;
      fault_counter   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          done <= 1'b0;
          if (start) begin
            page_q   <= in_page;
            offset_q <= logical_address[OffW-1:0];
            state    <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          done             <= 1'b1;
          physical_address <= pa_wide[AddrW-1:0];
          frame_number     <= frame_sel;
          page_number      <= search_page;
          tlb_hit          <= hit;
          page_fault       <= fault;
          lookup_total     <= sat_inc(lookup_counter);
          lookup_counter   <= sat_inc(lookup_counter);
          hit_total        <= hit ? sat_inc(hit_counter) : hit_counter;
          fault_total      <= fault ? sat_inc(fault_counter) : fault_counter;
          if (hit) begin
            hit_counter <= sat_inc(hit_counter);
          end
          if (fault) begin
            fault_counter <= sat_inc(fault_counter);
            if (next_free_frame != NffMax) begin
              next_free_frame <= next_free_frame + nff_t'(1);
            end
          end
          state <= ST_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_tlb_unique: assert property (@(posedge clk) disable iff (rst) $onehot0(match))
    else $error("tlb holds a page twice");
  a_hit_no_fault: assert property (@(posedge clk) disable iff (rst)
    done && tlb_hit |-> !page_fault)
    else $error("tlb hit reported as fault");
  a_look_done: assert property (@(posedge clk) disable iff (rst) busy |=> done)
    else $error("lookup did not produce a result");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("accepted item did not enter lookup");

endmodule
